// ===== hw/rtl/mstt_pkg.sv =====
`default_nettype none

package mstt_pkg;

    localparam int TIME_W      = 48;
    localparam int ID_W        = 32;
    localparam int DLY_W       = 32;
    localparam int IN_TAG_W    = 16;
    localparam int OUT_TAG_W   = 16;
    localparam int OPCODE_W    = 3;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_STOP_ALL = 3'd2,
        OP_PROCESS  = 3'd3,
        OP_QUERY    = 3'd4
    } opcode_t;

    typedef enum logic {
        ALU_SUB     = 1'b0,
        ALU_ADD_SAT = 1'b1
    } alu_mode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_slot_timer_table.sv =====
// Channel | Direction | Ports                      | Beat contents
// s_      | input     | s_tvalid s_tready s_tdata  | one timer operation
// m_      | output    | m_tvalid m_tready m_tdata  | one result per operation
// An operation walks the slot table one slot per cycle through a two-stage read pipeline.
// Start, stop, process and query scan; stop all and unknown opcodes skip the scan.
// A start, a periodic fire or a query with active slots ends with a step on the shared
// 48-bit adder. Reset clears the active bits and sets the id counter to 1.
// A finished result waits in the output register, and the next beat is taken meanwhile.
`default_nettype none

module multi_slot_timer_table #(
    parameter int TIMER_SLOTS = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // opcode[2:0], now_ms[50:3], delay_ms[82:51], interval_ms[114:83],
    // callback_tag[130:115], timer_id[162:131], zero fill above.
    input  wire [mstt_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // status[0], result_id[32:1], fired[33], fired_tag[49:34],
    // next_delay_ms[97:50], no_timer[98], zero fill above.
    output logic [mstt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t                             state_reg, state_next;
    mstt_pkg::opcode_t                  op_reg, op_next;
    logic [mstt_pkg::TIME_W-1:0]        now_reg, now_next;
    logic [mstt_pkg::DLY_W-1:0]         delay_reg, delay_next;
    logic [mstt_pkg::DLY_W-1:0]         intv_reg, intv_next;
    logic [TAG_BITS-1:0]                tag_reg, tag_next;
    logic [mstt_pkg::ID_W-1:0]          want_reg, want_next;

    logic [CNT_W-1:0]                   issue_cnt_reg, issue_cnt_next;
    logic                               pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]                   pipe_idx_reg, pipe_idx_next;
    logic [mstt_pkg::TIME_W-1:0]        min_reg, min_next;
    logic                               any_reg, any_next;
    logic [IDX_W-1:0]                   hit_idx_reg, hit_idx_next;
    logic [mstt_pkg::DLY_W-1:0]         hit_intv_reg, hit_intv_next;

    logic                               res_status_reg, res_status_next;
    logic [mstt_pkg::ID_W-1:0]          res_rid_reg, res_rid_next;
    logic                               res_fired_reg, res_fired_next;
    logic [mstt_pkg::OUT_TAG_W-1:0]     res_tag_reg, res_tag_next;
    logic [mstt_pkg::TIME_W-1:0]        res_nd_reg, res_nd_next;
    logic                               res_none_reg, res_none_next;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic [mstt_pkg::OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [TIMER_SLOTS-1:0]             active_reg, active_next;
    logic [mstt_pkg::ID_W-1:0]          next_id_reg, next_id_next;

    logic [mstt_pkg::ID_W-1:0]          id_mem   [TIMER_SLOTS];
    logic [mstt_pkg::TIME_W-1:0]        fire_mem [TIMER_SLOTS];
    logic [mstt_pkg::DLY_W-1:0]         intv_mem [TIMER_SLOTS];
    logic [TAG_BITS-1:0]                tag_mem  [TIMER_SLOTS];

    logic [mstt_pkg::ID_W-1:0]          id_rd_reg;
    logic [mstt_pkg::TIME_W-1:0]        fire_rd_reg;
    logic [mstt_pkg::DLY_W-1:0]         intv_rd_reg;
    logic [TAG_BITS-1:0]                tag_rd_reg;

    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;
    logic                               ent_we;
    logic                               fire_we;

    mstt_pkg::alu_mode_t                alu_mode;
    logic [mstt_pkg::TIME_W-1:0]        alu_a;
    logic [mstt_pkg::TIME_W-1:0]        alu_b;
    logic [mstt_pkg::TIME_W-1:0]        alu_res;
    logic                               alu_borrow;

    logic                               slot_act;
    logic                               last_slot;

    mstt_alu u_alu (
        .mode   (alu_mode),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_en     = (state_reg == ST_SCAN) && (issue_cnt_reg != CNT_W'(TIMER_SLOTS));
    assign rd_addr   = issue_cnt_reg[IDX_W-1:0];
    assign slot_act  = active_reg[pipe_idx_reg];
    assign last_slot = (pipe_idx_reg == IDX_W'(TIMER_SLOTS - 1));

    always_comb begin
        alu_mode = mstt_pkg::ALU_SUB;
        alu_a    = now_reg;
        alu_b    = fire_rd_reg;
        if (state_reg == ST_FINISH) begin
            unique case (op_reg)
                mstt_pkg::OP_START: begin
                    alu_mode = mstt_pkg::ALU_ADD_SAT;
                    alu_b    = mstt_pkg::TIME_W'(delay_reg);
                end
                mstt_pkg::OP_PROCESS: begin
                    alu_mode = mstt_pkg::ALU_ADD_SAT;
                    alu_b    = mstt_pkg::TIME_W'(hit_intv_reg);
                end
                mstt_pkg::OP_QUERY: begin
                    alu_a = min_reg;
                    alu_b = now_reg;
                end
                default: begin
                    alu_a = now_reg;
                end
            endcase
        end else if (op_reg == mstt_pkg::OP_QUERY) begin
            alu_a = fire_rd_reg;
            alu_b = min_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        intv_next       = intv_reg;
        tag_next        = tag_reg;
        want_next       = want_reg;
        issue_cnt_next  = issue_cnt_reg;
        pipe_vld_next   = rd_en;
        pipe_idx_next   = rd_addr;
        min_next        = min_reg;
        any_next        = any_reg;
        hit_idx_next    = hit_idx_reg;
        hit_intv_next   = hit_intv_reg;
        res_status_next = res_status_reg;
        res_rid_next    = res_rid_reg;
        res_fired_next  = res_fired_reg;
        res_tag_next    = res_tag_reg;
        res_nd_next     = res_nd_reg;
        res_none_next   = res_none_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        active_next     = active_reg;
        next_id_next    = next_id_reg;
        ent_we          = 1'b0;
        fire_we         = 1'b0;

        if (rd_en) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = mstt_pkg::opcode_t'(s_tdata[2:0]);
                    now_next        = s_tdata[50:3];
                    delay_next      = s_tdata[82:51];
                    intv_next       = s_tdata[114:83];
                    tag_next        = TAG_BITS'(s_tdata[130:115]);
                    want_next       = s_tdata[162:131];
                    issue_cnt_next  = '0;
                    any_next        = 1'b0;
                    res_status_next = 1'b0;
                    res_rid_next    = '0;
                    res_fired_next  = 1'b0;
                    res_tag_next    = '0;
                    res_nd_next     = '0;
                    res_none_next   = 1'b0;
                    unique case (mstt_pkg::opcode_t'(s_tdata[2:0]))
                        mstt_pkg::OP_START,
                        mstt_pkg::OP_STOP,
                        mstt_pkg::OP_PROCESS,
                        mstt_pkg::OP_QUERY: begin
                            state_next = ST_SCAN;
                        end
                        mstt_pkg::OP_STOP_ALL: begin
                            active_next = '0;
                            state_next  = ST_DONE;
                        end
                        default: begin
                            res_status_next = 1'b1;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (pipe_vld_reg) begin
                    unique case (op_reg)
                        mstt_pkg::OP_START: begin
                            if (!slot_act) begin
                                hit_idx_next  = pipe_idx_reg;
                                pipe_vld_next = 1'b0;
                                state_next    = ST_FINISH;
                            end else if (last_slot) begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end
                        end
                        mstt_pkg::OP_STOP: begin
                            if (slot_act && id_rd_reg == want_reg) begin
                                active_next[pipe_idx_reg] = 1'b0;
                                pipe_vld_next             = 1'b0;
                                state_next                = ST_DONE;
                            end else if (last_slot) begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end
                        end
                        mstt_pkg::OP_PROCESS: begin
                            if (slot_act && !alu_borrow) begin
                                res_fired_next = 1'b1;
                                res_rid_next   = id_rd_reg;
                                res_tag_next   = mstt_pkg::OUT_TAG_W'(tag_rd_reg);
                                hit_idx_next   = pipe_idx_reg;
                                hit_intv_next  = intv_rd_reg;
                                pipe_vld_next  = 1'b0;
                                if (intv_rd_reg == '0) begin
                                    active_next[pipe_idx_reg] = 1'b0;
                                    state_next                = ST_DONE;
                                end else begin
                                    state_next = ST_FINISH;
                                end
                            end else if (last_slot) begin
                                state_next = ST_DONE;
                            end
                        end
                        mstt_pkg::OP_QUERY: begin
                            if (slot_act && (!any_reg || alu_borrow)) begin
                                min_next = fire_rd_reg;
                            end
                            any_next = any_reg || slot_act;
                            if (last_slot) begin
                                if (any_reg || slot_act) begin
                                    state_next = ST_FINISH;
                                end else begin
                                    res_none_next = 1'b1;
                                    state_next    = ST_DONE;
                                end
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_FINISH: begin
                unique case (op_reg)
                    mstt_pkg::OP_START: begin
                        ent_we                   = 1'b1;
                        fire_we                  = 1'b1;
                        active_next[hit_idx_reg] = 1'b1;
                        res_rid_next             = next_id_reg;
                        next_id_next             = next_id_reg + mstt_pkg::ID_W'(1);
                    end
                    mstt_pkg::OP_PROCESS: begin
                        fire_we = 1'b1;
                    end
                    mstt_pkg::OP_QUERY: begin
                        res_nd_next = alu_borrow ? '0 : alu_res;
                    end
                    default: begin
                        res_nd_next = '0;
                    end
                endcase
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = mstt_pkg::OUT_TDATA_W'({res_none_reg, res_nd_reg,
                                                            res_tag_reg, res_fired_reg,
                                                            res_rid_reg, res_status_reg});
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            id_rd_reg   <= id_mem[rd_addr];
            fire_rd_reg <= fire_mem[rd_addr];
            intv_rd_reg <= intv_mem[rd_addr];
            tag_rd_reg  <= tag_mem[rd_addr];
        end
        if (ent_we) begin
            id_mem[hit_idx_reg]   <= next_id_reg;
            intv_mem[hit_idx_reg] <= intv_reg;
            tag_mem[hit_idx_reg]  <= tag_reg;
        end
        if (fire_we) begin
            fire_mem[hit_idx_reg] <= alu_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pipe_vld_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            active_reg    <= '0;
            next_id_reg   <= mstt_pkg::ID_W'(1);
        end else begin
            state_reg     <= state_next;
            pipe_vld_reg  <= pipe_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
            active_reg    <= active_next;
            next_id_reg   <= next_id_next;
        end
        op_reg         <= op_next;
        now_reg        <= now_next;
        delay_reg      <= delay_next;
        intv_reg       <= intv_next;
        tag_reg        <= tag_next;
        want_reg       <= want_next;
        issue_cnt_reg  <= issue_cnt_next;
        pipe_idx_reg   <= pipe_idx_next;
        min_reg        <= min_next;
        any_reg        <= any_next;
        hit_idx_reg    <= hit_idx_next;
        hit_intv_reg   <= hit_intv_next;
        res_status_reg <= res_status_next;
        res_rid_reg    <= res_rid_next;
        res_fired_reg  <= res_fired_next;
        res_tag_reg    <= res_tag_next;
        res_nd_reg     <= res_nd_next;
        res_none_reg   <= res_none_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_pipe_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> state_reg == ST_SCAN)
        else $error("Read pipeline is busy outside the scan.");

    a_id_advances_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_id_reg != $past(next_id_reg)) |->
            $past(state_reg == ST_FINISH && op_reg == mstt_pkg::OP_START))
        else $error("Id counter moved without a successful start.");

    a_one_slot_per_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(active_reg) <= $countones($past(active_reg)) + 1)
        else $error("More than one slot was taken in one cycle.");

    a_fired_is_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[33]) |-> !m_tdata_reg[0])
        else $error("A fired result carries a failure status.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mstt_alu.sv =====
`default_nettype none

module mstt_alu (
    input  var mstt_pkg::alu_mode_t         mode,
    input  wire [mstt_pkg::TIME_W-1:0]      a,
    input  wire [mstt_pkg::TIME_W-1:0]      b,
    output logic [mstt_pkg::TIME_W-1:0]     res,
    output logic                            borrow
);

    logic [mstt_pkg::TIME_W-1:0] opb;
    logic                        cin;
    logic [mstt_pkg::TIME_W:0]   sum;

    always_comb begin
        opb = (mode == mstt_pkg::ALU_SUB) ? ~b : b;
        cin = (mode == mstt_pkg::ALU_SUB);
        sum = {1'b0, a} + {1'b0, opb} + {{mstt_pkg::TIME_W{1'b0}}, cin};
        unique case (mode)
            mstt_pkg::ALU_ADD_SAT: begin
                res    = sum[mstt_pkg::TIME_W] ? '1 : sum[mstt_pkg::TIME_W-1:0];
                borrow = 1'b0;
            end
            mstt_pkg::ALU_SUB: begin
                res    = sum[mstt_pkg::TIME_W-1:0];
                borrow = ~sum[mstt_pkg::TIME_W];
            end
            default: begin
                res    = '0;
                borrow = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
